@@ rtl/core/ray_box_slab_intersect_defines.svh @@
// Assertion macros for the ray/box slab intersection checker.
`ifndef RAY_BOX_SLAB_INTERSECT_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECT_DEFINES_SVH

// Checked property, ignored while reset is high
`define RBSI_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rbsi: port check failed");

// Checked property that also covers the reset cycles
`define RBSI_CHECK_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rbsi: reset check failed");

`endif

@@ rtl/core/rbsi_pkg.sv @@
// Shared types and constants of the ray/box slab intersection block.
package rbsi_pkg;

  localparam int NUM_AXES    = 3;
  localparam int NUM_SLABS   = 2 * NUM_AXES;
  localparam int COORD_W     = 32;
  localparam int DIR_W       = 18;
  localparam int DIST_W      = 31;
  localparam int QUO_W       = 32;
  localparam int STEP_BITS   = 4;
  localparam int DIV_STAGES  = QUO_W / STEP_BITS;
  // entry stage, divider stages, saturate/order, min/max, output register
  localparam int NUM_STAGES  = DIV_STAGES + 4;
  localparam int IN_W        = NUM_SLABS * COORD_W;
  localparam int OUT_W       = 32;

  localparam logic [QUO_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [QUO_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5,
    REG_MAX_DIST = 3'd6
  } cfg_reg_t;

  // one slab distance in flight through the long divider
  typedef struct packed {
    logic [DIR_W-1:0] rem;   // partial remainder, below the divisor
    logic [QUO_W-1:0] low;   // dividend bits still to be shifted in
    logic [QUO_W-1:0] quo;   // quotient magnitude built so far
    logic             neg;   // quotient sign
    logic             ovf;   // magnitude at least 2^32
  } div_t;

endpackage

@@ rtl/core/ray_box_slab_intersect.sv @@
// Ray versus axis-aligned box test by the slab method, fully pipelined.
//
// One box is accepted per cycle while the output side does not stall, and its
// result passes through twelve register stages.
// The depth is set by six slab distance dividers running side by side, each
// a long divider that resolves four quotient bits in each of eight stages; one
// stage forms the corner offsets before them, and three stages after them
// saturate and order the distances, narrow the [enter, exit] interval and
// register the result. Each stage holds its beat while the next cannot move,
// so bubbles close up and a stall loses nothing.
// The ray (origin, direction, distance bound) is to be written through the cfg
// port only while no box is in flight; the block itself does not enforce this.
module ray_box_slab_intersect
  import rbsi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // box in: min_x, min_y, min_z, max_x, max_y, max_z (32 bits each, low first)
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  // result out: hit [0], entry_distance [31:1]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  // register write port
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  localparam int ST_SAT = DIV_STAGES + 1;
  localparam int ST_MM  = DIV_STAGES + 2;
  localparam int ST_OUT = DIV_STAGES + 3;

  // ray registers
  logic signed [COORD_W-1:0] origin [NUM_AXES];
  logic signed [DIR_W-1:0]   dir    [NUM_AXES];
  logic        [DIST_W-1:0]  max_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        origin[a] <= '0;
        dir[a]    <= '0;
      end
      dir[2]       <= 18'sd65536;
      max_distance <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin[0]    <= cfg_data;
        REG_ORIGIN_Y: origin[1]    <= cfg_data;
        REG_ORIGIN_Z: origin[2]    <= cfg_data;
        REG_DIR_X:    dir[0]       <= cfg_data[DIR_W-1:0];
        REG_DIR_Y:    dir[1]       <= cfg_data[DIR_W-1:0];
        REG_DIR_Z:    dir[2]       <= cfg_data[DIR_W-1:0];
        REG_MAX_DIST: max_distance <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // divisor magnitudes and parallel-axis flags
  logic [DIR_W-1:0] dmag     [NUM_AXES];
  logic             dir_zero [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      dmag[a]     = dir[a][DIR_W-1] ? DIR_W'(-dir[a]) : DIR_W'(dir[a]);
      dir_zero[a] = (dir[a] == '0);
    end
  end

  // stage valids and per-stage load enables (a stage moves if it is empty
  // or the stage after it moves)
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || m_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign s_tready = en[0];

  // payload registers
  div_t                     dv   [DIV_STAGES+1][NUM_SLABS];
  logic                     miss [ST_MM+1];
  logic signed [QUO_W-1:0]  tlo  [NUM_AXES];
  logic signed [QUO_W-1:0]  thi  [NUM_AXES];
  logic signed [QUO_W-1:0]  t_enter;
  logic signed [QUO_W-1:0]  t_exit;
  logic                     hit;
  logic [DIST_W-1:0]        entry_distance;

  // entry stage: corner offsets, overflow check, parallel-axis test
  div_t dv_in [NUM_SLABS];
  logic miss_in;

  always_comb begin
    logic signed [COORD_W:0] diff;
    logic        [COORD_W:0] mag;
    logic signed [COORD_W-1:0] lo;
    logic signed [COORD_W-1:0] hi;
    int ax;
    miss_in = 1'b0;
    for (int s = 0; s < NUM_SLABS; s++) begin
      ax   = s % NUM_AXES;
      diff = {s_tdata[COORD_W*s + COORD_W-1], s_tdata[COORD_W*s +: COORD_W]}
             - {origin[ax][COORD_W-1], origin[ax]};
      mag  = diff[COORD_W] ? (COORD_W+1)'(-diff) : (COORD_W+1)'(diff);
      dv_in[s].rem = {2'b00, mag[31:16]};
      dv_in[s].low = {mag[15:0], 16'h0000};
      dv_in[s].quo = '0;
      dv_in[s].neg = diff[COORD_W] ^ dir[ax][DIR_W-1];
      dv_in[s].ovf = ({2'b00, mag[31:16]} >= dmag[ax]);
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      lo = s_tdata[COORD_W*a +: COORD_W];
      hi = s_tdata[COORD_W*(a+NUM_AXES) +: COORD_W];
      if (dir_zero[a] && (origin[a] < lo || origin[a] > hi)) begin
        miss_in = 1'b1;
      end
    end
  end

  // long divider steps, four quotient bits per stage
  div_t dv_next [DIV_STAGES][NUM_SLABS];

  always_comb begin
    logic [DIR_W-1:0] r;
    for (int k = 0; k < DIV_STAGES; k++) begin
      for (int s = 0; s < NUM_SLABS; s++) begin
        dv_next[k][s] = dv[k][s];
        for (int j = 0; j < STEP_BITS; j++) begin
          r = {dv_next[k][s].rem[DIR_W-2:0], dv_next[k][s].low[QUO_W-1]};
          dv_next[k][s].low = {dv_next[k][s].low[QUO_W-2:0], 1'b0};
          if (r >= dmag[s % NUM_AXES]) begin
            dv_next[k][s].rem = r - dmag[s % NUM_AXES];
            dv_next[k][s].quo = {dv_next[k][s].quo[QUO_W-2:0], 1'b1};
          end else begin
            dv_next[k][s].rem = r;
            dv_next[k][s].quo = {dv_next[k][s].quo[QUO_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dv[0]   <= dv_in;
      miss[0] <= miss_in;
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (en[k]) begin
        dv[k]   <= dv_next[k-1];
        miss[k] <= miss[k-1];
      end
    end
  end

  // saturate quotients to Q16.16 and order each axis pair
  logic signed [QUO_W-1:0] t_sat [NUM_SLABS];
  logic signed [QUO_W-1:0] tlo_next [NUM_AXES];
  logic signed [QUO_W-1:0] thi_next [NUM_AXES];

  always_comb begin
    for (int s = 0; s < NUM_SLABS; s++) begin
      if (!dv[DIV_STAGES][s].neg) begin
        t_sat[s] = (dv[DIV_STAGES][s].ovf || dv[DIV_STAGES][s].quo[QUO_W-1])
                   ? SAT_POS : dv[DIV_STAGES][s].quo;
      end else begin
        t_sat[s] = (dv[DIV_STAGES][s].ovf || dv[DIV_STAGES][s].quo > SAT_NEG)
                   ? SAT_NEG : QUO_W'(-dv[DIV_STAGES][s].quo);
      end
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      if (t_sat[a] > t_sat[a+NUM_AXES]) begin
        tlo_next[a] = t_sat[a+NUM_AXES];
        thi_next[a] = t_sat[a];
      end else begin
        tlo_next[a] = t_sat[a];
        thi_next[a] = t_sat[a+NUM_AXES];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SAT]) begin
      tlo          <= tlo_next;
      thi          <= thi_next;
      miss[ST_SAT] <= miss[DIV_STAGES];
    end
  end

  // narrow the interval from [0, max_distance] over non-parallel axes
  logic signed [QUO_W-1:0] enter_next;
  logic signed [QUO_W-1:0] exit_next;

  always_comb begin
    enter_next = '0;
    exit_next  = {1'b0, max_distance};
    for (int a = 0; a < NUM_AXES; a++) begin
      if (!dir_zero[a]) begin
        if (tlo[a] > enter_next) enter_next = tlo[a];
        if (thi[a] < exit_next)  exit_next  = thi[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_MM]) begin
      t_enter     <= enter_next;
      t_exit      <= exit_next;
      miss[ST_MM] <= miss[ST_SAT];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      hit            <= !miss[ST_MM] && !(t_enter > t_exit);
      entry_distance <= (!miss[ST_MM] && !(t_enter > t_exit))
                        ? t_enter[DIST_W-1:0] : '0;
    end
  end

  assign m_tvalid = vld[ST_OUT];
  assign m_tdata  = {entry_distance, hit};

endmodule

@@ rtl/core/rbsi_checker.sv @@
// Port-level checks of the ray/box slab intersection block, bound to the top.
`include "ray_box_slab_intersect_defines.svh"

module rbsi_checker
  import rbsi_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // a stalled result beat holds
  `RBSI_CHECK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // a miss reports zero entry distance
  `RBSI_CHECK(a_miss_zero, m_tvalid && !m_tdata[0] |-> m_tdata[DIST_W:1] == '0)

  // the pipeline is empty after reset
  `RBSI_CHECK_RST(a_rst_empty, rst |=> !m_tvalid)

endmodule

bind ray_box_slab_intersect rbsi_checker u_rbsi_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ verif/tb_ray_box_slab_intersect.sv @@
// Testbench for the ray/box slab intersection block: directed and random boxes vs a predictor.
module tb_ray_box_slab_intersect;
  import rbsi_pkg::*;

  typedef struct {
    logic        hit;
    logic [30:0] entry;
  } slab_result_t;

  // Scoreboard: predicts each accepted box and checks results in order
  class slab_scoreboard;
    longint origin[3];
    longint dir[3];
    longint max_dist;
    slab_result_t pending[$];
    int errors;
    int boxes;
    int hits;

    function void reset_ray();
      for (int a = 0; a < 3; a++) begin
        origin[a] = 0;
        dir[a] = 0;
      end
      dir[2] = 65536;
      max_dist = 64'h7FFF_FFFF;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] v);
      case (idx)
        REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z: begin
          origin[idx] = longint'($signed(v));
        end
        REG_DIR_X, REG_DIR_Y, REG_DIR_Z: begin
          dir[idx - REG_DIR_X] = longint'($signed(v[17:0]));
        end
        REG_MAX_DIST: begin
          max_dist = longint'(v[30:0]);
        end
        default: ;
      endcase
    endfunction

    // slab distance: exact quotient truncated toward zero, then saturated
    function longint slab_t(longint corner, longint o, longint d);
      longint q;
      q = ((corner - o) * 65536) / d;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q;
    endfunction

    function void note_box(logic [IN_W-1:0] box);
      longint t_in, t_out, lo, hi, t1, t2, tmp;
      logic ok;
      slab_result_t r;
      t_in = 0;
      t_out = max_dist;
      ok = 1'b1;
      for (int a = 0; a < 3 && ok; a++) begin
        lo = longint'($signed(box[a*32 +: 32]));
        hi = longint'($signed(box[(a+3)*32 +: 32]));
        if (dir[a] == 0) begin
          if (origin[a] < lo || origin[a] > hi) ok = 1'b0;
        end else begin
          t1 = slab_t(lo, origin[a], dir[a]);
          t2 = slab_t(hi, origin[a], dir[a]);
          if (t1 > t2) begin
            tmp = t1;
            t1 = t2;
            t2 = tmp;
          end
          if (t1 > t_in) t_in = t1;
          if (t2 < t_out) t_out = t2;
          if (t_in > t_out) ok = 1'b0;
        end
      end
      r.hit = ok;
      r.entry = ok ? t_in[30:0] : 31'd0;
      pending.push_back(r);
      boxes++;
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      slab_result_t e;
      if (pending.size() == 0) begin
        $error("result beat with no box pending: %h", data);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data[0] !== e.hit) begin
        $error("hit: expected %0d, got %0d", e.hit, data[0]);
        errors++;
      end
      if (data[31:1] !== e.entry) begin
        $error("entry_distance: expected %h, got %h", e.entry, data[31:1]);
        errors++;
      end
      if (e.hit) hits++;
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;   // min_x, min_y, min_z, max_x, max_y, max_z
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;        // hit, entry_distance
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [31:0]      cfg_data = '0;

  slab_scoreboard sb;
  int  idle_cycles = 0;

  always #5 clk = ~clk;

  ray_box_slab_intersect dut (.*);

  // Watch both sides: score beats, count cycles with no beat accepted
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_box(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver: random ready gaps, with stretches of none
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      repeat (gap) @(posedge clk) m_tready <= 1'b0;
      @(posedge clk) m_tready <= 1'b1;
      while (!(m_tvalid && m_tready)) @(posedge clk);
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // called at a clock edge; holds the beat until it is accepted
  task automatic send_box(logic [IN_W-1:0] box, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= box;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [IN_W-1:0] pack_box(logic [31:0] lx, ly, lz, hx, hy, hz);
    return {hz, hy, hx, lz, ly, lx};
  endfunction

  // coordinate near the origin, sometimes anywhere in range
  function automatic logic [31:0] rand_coord(int axis);
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'(sb.origin[axis]) + 32'($signed(32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000));
  endfunction

  function automatic logic [IN_W-1:0] rand_box();
    logic [31:0] lo[3], hi[3], t;
    for (int a = 0; a < 3; a++) begin
      lo[a] = rand_coord(a);
      hi[a] = rand_coord(a);
      if ($signed(lo[a]) > $signed(hi[a]) && $urandom_range(0, 9) != 0) begin
        t = lo[a];
        lo[a] = hi[a];
        hi[a] = t;
      end
    end
    return pack_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  function automatic logic [31:0] rand_dir();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'($signed(18'($urandom)));
      2: return 32'(65536);
      3: return 32'(-65536);
      default: return 32'($signed(18'($urandom_range(0, 131072)) - 18'd65536));
    endcase
  endfunction

  task automatic random_ray();
    write_reg(REG_ORIGIN_X, ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000));
    write_reg(REG_ORIGIN_Y, ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000));
    write_reg(REG_ORIGIN_Z, ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000));
    write_reg(REG_DIR_X, rand_dir());
    write_reg(REG_DIR_Y, rand_dir());
    write_reg(REG_DIR_Z, rand_dir());
    write_reg(REG_MAX_DIST, ($urandom_range(0, 2) == 0) ? 32'h7FFF_FFFF : 32'($urandom_range(0, 32'h00FF_FFFF)));
  endtask

  initial begin
    sb = new();
    sb.reset_ray();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset ray along +z, box extremes
    send_box(pack_box(32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000,
                      32'h0001_0000, 32'h0001_0000, 32'h0002_0000), 0);
    send_box(pack_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1);
    send_box(pack_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1);
    // parallel axis, origin outside the slab
    send_box(pack_box(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000,
                      32'h0002_0000, 32'h0001_0000, 32'h0002_0000), 0);
    // box behind the origin
    send_box(pack_box(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFE_0000,
                      32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000), 0);
    wait_drained();

    // Directed: extreme origin and directions, saturation, small bound
    write_reg(REG_ORIGIN_X, 32'h8000_0000);
    write_reg(REG_ORIGIN_Y, 32'h7FFF_FFFF);
    write_reg(REG_ORIGIN_Z, 32'h0000_0000);
    write_reg(REG_DIR_X, 32'(1));
    write_reg(REG_DIR_Y, 32'(-1));
    write_reg(REG_DIR_Z, 32'h0002_0000);   // most negative 18-bit value
    write_reg(REG_MAX_DIST, 32'h0000_0000);
    send_box(pack_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0);
    send_box(pack_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000), 1);
    send_box('1, 0);
    send_box('0, 0);
    wait_drained();
    write_reg(REG_DIR_X, 32'h0001_FFFF);
    write_reg(REG_DIR_Y, 32'(-65536));
    write_reg(REG_MAX_DIST, 32'h7FFF_FFFF);
    send_box(pack_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0);
    send_box(pack_box(32'h8000_0000, 32'h0000_0000, 32'hFFFF_0000,
                      32'h8001_0000, 32'h7FFF_FFFF, 32'h0001_0000), 0);
    send_box(32'hAAAA_5555 * 192'h1_0000_0001_0000_0001_0000_0001, 0);
    wait_drained();

    // Random phases: new ray, then a burst of boxes
    for (int ph = 0; ph < 35; ph++) begin
      random_ray();
      for (int i = 0; i < 50; i++) send_box(rand_box(), $urandom_range(0, 3) == 0);
      wait_drained();
    end

    $display("boxes checked: %0d, hits: %0d, ray settings: 37",
             sb.boxes, sb.hits);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
